// ----- hw/rtl/s3x_pkg.sv -----
`timescale 1ns / 1ps

package s3x_pkg;

    localparam int MAX_SIDE    = 512;
    localparam int CW          = $clog2(MAX_SIDE);
    localparam int STORE_AW    = 2 * CW;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    localparam int PIX_W      = 32;
    localparam int COORD_W    = 9;
    localparam int SZ_W       = 10;
    localparam int POS_W      = SZ_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = SZ_W;
    localparam int NB_NUM     = 9;

    typedef logic [PIX_W-1:0]      t_pixel;
    typedef logic [COORD_W-1:0]    t_coord;
    typedef logic [SZ_W-1:0]       t_size;
    typedef logic [POS_W-1:0]      t_pos;
    typedef logic [STORE_AW-1:0]   t_addr;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_index;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 4'd0,
        CFG_HEIGHT = 4'd1,
        CFG_WRAP_H = 4'd2,
        CFG_WRAP_V = 4'd3
    } t_cfg_reg;

    typedef enum logic [0:0] {
        MODE_LOAD = 1'b0,
        MODE_EMIT = 1'b1
    } t_mode;

    // neighbor slots in read order, row major around the center pixel
    typedef enum logic [3:0] {
        NB_UL = 4'd0,
        NB_U  = 4'd1,
        NB_UR = 4'd2,
        NB_L  = 4'd3,
        NB_E  = 4'd4,
        NB_R  = 4'd5,
        NB_WL = 4'd6,
        NB_W  = 4'd7,
        NB_WR = 4'd8
    } t_nb;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_DRAIN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic write;
        logic capture;
        logic prep;
        logic rd_en;
        t_nb  rd_idx;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        t_pixel x0_y0;
        t_pixel x0_y1;
        t_pixel x0_y2;
        t_pixel x1_y0;
        t_pixel x1_y1;
        t_pixel x1_y2;
        t_pixel x2_y0;
        t_pixel x2_y1;
        t_pixel x2_y2;
    } t_block;

    function automatic t_size eff_size(input t_size v);
        t_size r;
        if (v == '0) begin
            r = t_size'(1);
        end else if (32'(v) > MAX_SIDE) begin
            r = t_size'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/s3x_if.sv -----
`timescale 1ns / 1ps

interface s3x_px_if;
    import s3x_pkg::*;
    logic   valid;
    logic   ready;
    logic   mode;
    t_coord column;
    t_coord line;
    t_pixel pixel_in;
    modport source (output valid, mode, column, line, pixel_in, input ready);
    modport sink   (input valid, mode, column, line, pixel_in, output ready);
endinterface

interface s3x_blk_if;
    import s3x_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel out_x0_y0;
    t_pixel out_x0_y1;
    t_pixel out_x0_y2;
    t_pixel out_x1_y0;
    t_pixel out_x1_y1;
    t_pixel out_x1_y2;
    t_pixel out_x2_y0;
    t_pixel out_x2_y1;
    t_pixel out_x2_y2;
    modport source (output valid, out_x0_y0, out_x0_y1, out_x0_y2, out_x1_y0,
                    out_x1_y1, out_x1_y2, out_x2_y0, out_x2_y1, out_x2_y2,
                    input ready);
    modport sink   (input valid, out_x0_y0, out_x0_y1, out_x0_y2, out_x1_y0,
                    out_x1_y1, out_x1_y2, out_x2_y0, out_x2_y1, out_x2_y2,
                    output ready);
endinterface

interface s3x_cfg_if;
    import s3x_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/s3x_ram.sv -----
`timescale 1ns / 1ps

module s3x_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/s3x_ctrl.sv -----
`timescale 1ns / 1ps

module s3x_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_mode,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output s3x_pkg::t_ctrl_cmd o_cmd
);
    import s3x_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.rd_idx = t_nb'(r_cnt);
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    if (i_in_mode == MODE_EMIT) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_PREP;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_cnt       = r_cnt + 4'd1;
                if (t_nb'(r_cnt) == NB_WR) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/s3x_datapath.sv -----
`timescale 1ns / 1ps

module s3x_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  s3x_pkg::t_ctrl_cmd  i_cmd,
    input  s3x_pkg::t_coord     i_column,
    input  s3x_pkg::t_coord     i_line,
    input  s3x_pkg::t_pixel     i_pixel_in,
    input  logic                i_cfg_valid,
    input  s3x_pkg::t_cfg_index i_cfg_index,
    input  s3x_pkg::t_cfg_data  i_cfg_data,
    output s3x_pkg::t_block     o_block
);
    import s3x_pkg::*;

    t_size  r_width, r_height;
    logic   r_wrap_h, r_wrap_v;
    t_coord r_col, r_line;
    t_pos   r_xl, r_xc, r_xr, r_yu, r_yc, r_yd;
    logic   r_pend;
    t_nb    r_pend_idx;
    t_pixel r_nb [NB_NUM];
    t_block r_block, n_block;

    t_size  w_eff, h_eff;
    t_pos   x_last, y_last, xc, yc;
    t_pos   rd_x, rd_y;
    t_addr  addr;
    logic   we;
    t_pixel rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= t_size'(1);
            r_height <= t_size'(1);
            r_wrap_h <= 1'b0;
            r_wrap_v <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_WRAP_H: r_wrap_h <= i_cfg_data[0];
                CFG_WRAP_V: r_wrap_v <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_eff  = eff_size(r_width);
    assign h_eff  = eff_size(r_height);
    assign x_last = t_pos'(w_eff - t_size'(1));
    assign y_last = t_pos'(h_eff - t_size'(1));
    assign xc     = (t_pos'(r_col) > x_last) ? x_last : t_pos'(r_col);
    assign yc     = (t_pos'(r_line) > y_last) ? y_last : t_pos'(r_line);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col  <= i_column;
            r_line <= i_line;
        end
        if (i_cmd.prep) begin
            r_xc <= xc;
            r_yc <= yc;
            r_xl <= (xc == '0) ? (r_wrap_h ? x_last : '0) : xc - t_pos'(1);
            r_xr <= (xc == x_last) ? (r_wrap_h ? '0 : xc) : xc + t_pos'(1);
            r_yu <= (yc == '0) ? (r_wrap_v ? y_last : '0) : yc - t_pos'(1);
            r_yd <= (yc == y_last) ? (r_wrap_v ? '0 : yc) : yc + t_pos'(1);
        end
    end

    always_comb begin
        unique case (i_cmd.rd_idx) inside
            NB_UL, NB_L, NB_WL: rd_x = r_xl;
            NB_UR, NB_R, NB_WR: rd_x = r_xr;
            default:            rd_x = r_xc;
        endcase
        unique case (i_cmd.rd_idx) inside
            NB_UL, NB_U, NB_UR: rd_y = r_yu;
            NB_WL, NB_W, NB_WR: rd_y = r_yd;
            default:            rd_y = r_yc;
        endcase
    end

    assign we = i_cmd.write && (32'(i_column) < MAX_SIDE) && (32'(i_line) < MAX_SIDE);

    always_comb begin
        if (i_cmd.write) begin
            addr = (t_addr'(i_line) << CW) | t_addr'(i_column);
        end else begin
            addr = (t_addr'(rd_y) << CW) | t_addr'(rd_x);
        end
    end

    s3x_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (i_pixel_in),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_en;
        end
        r_pend_idx <= i_cmd.rd_idx;
        if (r_pend) begin
            r_nb[r_pend_idx] <= rdata;
        end
    end

    always_comb begin
        t_pixel ul, u, ur, l, e, r, wl, w, wr;
        ul = r_nb[NB_UL];
        u  = r_nb[NB_U];
        ur = r_nb[NB_UR];
        l  = r_nb[NB_L];
        e  = r_nb[NB_E];
        r  = r_nb[NB_R];
        wl = r_nb[NB_WL];
        w  = r_nb[NB_W];
        wr = r_nb[NB_WR];
        n_block = '{default: e};
        if (u != w && l != r) begin
            n_block.x0_y0 = (l == u) ? l : e;
            n_block.x0_y1 = ((l == u && e != wl) || (l == w && e != ul)) ? l : e;
            n_block.x0_y2 = (l == w) ? l : e;
            n_block.x1_y0 = ((l == u && e != ur) || (u == r && e != ul)) ? u : e;
            n_block.x1_y2 = ((l == w && e != wr) || (w == r && e != wl)) ? w : e;
            n_block.x2_y0 = (u == r) ? r : e;
            n_block.x2_y1 = ((u == r && e != wr) || (w == r && e != ur)) ? r : e;
            n_block.x2_y2 = (w == r) ? r : e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_block <= n_block;
        end
    end

    assign o_block = r_block;

endmodule

// ----- hw/rtl/scale3x_pixel_upscaler_unit.sv -----
`timescale 1ns / 1ps

// Scale3x upscaler over a 512 x 512 frame store of 32-bit pixels. A load
// transfer writes one pixel and returns nothing. An emit transfer occupies
// the block through accept, coordinate setup, nine reads of the single-port
// frame store, one read drain and result, and yields one 3x3 block; the
// finished block waits in an output register while the next transfer is
// taken. Configuration writes are taken while reset is not asserted. The
// store is not cleared after reset; read only pixels that were loaded.
module scale3x_pixel_upscaler_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    s3x_px_if.sink    i_in,
    s3x_blk_if.source o_out,
    s3x_cfg_if.sink   i_cfg
);
    import s3x_pkg::*;

    t_ctrl_cmd cmd;
    t_block    blk;

    s3x_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    s3x_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_column    (i_in.column),
        .i_line      (i_in.line),
        .i_pixel_in  (i_in.pixel_in),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_block     (blk)
    );

    assign i_cfg.ready     = i_rst_n;
    assign o_out.out_x0_y0 = blk.x0_y0;
    assign o_out.out_x0_y1 = blk.x0_y1;
    assign o_out.out_x0_y2 = blk.x0_y2;
    assign o_out.out_x1_y0 = blk.x1_y0;
    assign o_out.out_x1_y1 = blk.x1_y1;
    assign o_out.out_x1_y2 = blk.x1_y2;
    assign o_out.out_x2_y0 = blk.x2_y0;
    assign o_out.out_x2_y1 = blk.x2_y1;
    assign o_out.out_x2_y2 = blk.x2_y2;

endmodule
